/* rtl/sic_pkg.sv */
// shared types, widths and the cell step function for the segment crossing block
// no dependencies
package sic_pkg;

    localparam int CW = 16;           // coordinate width
    localparam int DFW = CW + 1;      // coordinate difference width (signed)
    localparam int PW = 2 * DFW;      // product width (signed)
    localparam int DTW = PW + 1;      // determinant width (signed)
    localparam int DW = 2 * CW + 1;   // determinant magnitude width
    localparam int RW = DW + 2;       // partial remainder work width

    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] c_x;
        logic signed [CW-1:0] c_y;
        logic signed [CW-1:0] d_x;
        logic signed [CW-1:0] d_y;
    } in_t;

    typedef struct packed {
        logic                 crosses;
        logic signed [CW-1:0] cross_x;
        logic signed [CW-1:0] cross_y;
    } out_t;

    // one coordinate lane of the long division chain
    typedef struct packed {
        logic signed [CW-1:0] a0;
        logic                 neg;
        logic [CW-1:0]        m;
        logic [CW-1:0]        q;
        logic [DW-1:0]        r;
    } lane_t;

    typedef struct packed {
        logic          crosses;
        logic [DW-1:0] n;
        logic [DW-1:0] den;
        lane_t         lx;
        lane_t         ly;
    } cell_t;

    // one bit of |d|*n/den: shift remainder, add n on a set bit, reduce
    function automatic lane_t lane_step(lane_t l, logic [DW-1:0] n, logic [DW-1:0] den);
        lane_t         o;
        logic [RW-1:0] t;
        logic [RW-1:0] d1;
        logic [RW-1:0] d2;
        logic [1:0]    qi;
        o  = l;
        d1 = {2'b00, den};
        d2 = {1'b0, den, 1'b0};
        t  = {1'b0, l.r, 1'b0} + (l.m[CW-1] ? {2'b00, n} : {RW{1'b0}});
        if (t >= d2) begin
            t  = t - d2;
            qi = 2'd2;
        end else if (t >= d1) begin
            t  = t - d1;
            qi = 2'd1;
        end else begin
            qi = 2'd0;
        end
        o.r = t[DW-1:0];
        o.q = {l.q[CW-2:0], 1'b0} + {{(CW-2){1'b0}}, qi};
        o.m = {l.m[CW-2:0], 1'b0};
        return o;
    endfunction

endpackage

/* rtl/sic_cell.sv */
// one cell of the division chain: one quotient bit for both lanes per cycle while not stalled
// depends on sic_pkg
module sic_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  sic_pkg::cell_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output sic_pkg::cell_t  out_data
);

    logic           valid_reg;
    sic_pkg::cell_t data_reg;
    sic_pkg::cell_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next    = in_data;
        data_next.lx = sic_pkg::lane_step(in_data.lx, in_data.n, in_data.den);
        data_next.ly = sic_pkg::lane_step(in_data.ly, in_data.n, in_data.den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/segment_intersection_cramer.sv */
// segment crossing by cramer's rule through registered stages and a division chain
// throughput one beat per cycle unless stalled downstream; the one-bit-per-cell division chain has CW cells
// every stage holds a valid bit and stalls only when full and blocked downstream
// aresetn synchronous active low clears all valid bits; payload registers are not reset
// depends on sic_pkg and sic_cell
module segment_intersection_cramer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sic_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sic_pkg::out_t  m_data
);

    localparam int CW  = sic_pkg::CW;
    localparam int DFW = sic_pkg::DFW;
    localparam int PW  = sic_pkg::PW;
    localparam int DTW = sic_pkg::DTW;
    localparam int DW  = sic_pkg::DW;

    // stage 1: coordinate differences
    logic                  v1_reg;
    logic signed [DFW-1:0] abx_reg, aby_reg, ncdx_reg, ncdy_reg, acx_reg, acy_reg;
    logic signed [CW-1:0]  ax1_reg, ay1_reg;
    // stage 2: products
    logic                  v2_reg;
    logic signed [PW-1:0]  p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [DFW-1:0] abx2_reg, aby2_reg;
    logic signed [CW-1:0]  ax2_reg, ay2_reg;
    // stage 3: determinants
    logic                  v3_reg;
    logic signed [DTW-1:0] delta_reg, delta1_reg, delta2_reg;
    logic signed [DFW-1:0] abx3_reg, aby3_reg;
    logic signed [CW-1:0]  ax3_reg, ay3_reg;
    // stage 4: crossing test and magnitudes, head of the cell chain
    logic                  v4_reg;
    sic_pkg::cell_t        c4_reg;
    sic_pkg::cell_t        c4_next;
    // output register
    logic                  vo_reg;
    sic_pkg::out_t         out_reg;
    sic_pkg::out_t         out_next;

    logic rdy1, rdy2, rdy3, rdy4, rdyo;

    // cell chain wiring: index 0 is stage 4, index CW is the chain tail
    logic           chain_valid [CW+1];
    logic           chain_ready [CW+1];
    sic_pkg::cell_t chain_data  [CW+1];

    // ready ripples back from the output register
    assign rdyo    = !vo_reg || m_ready;
    assign rdy4    = !v4_reg || chain_ready[0];
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdyo) begin
                vo_reg <= chain_valid[CW];
            end
        end
    end

    // stage 1: differences, negated cd direction
    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            abx_reg  <= DFW'(s_data.b_x) - DFW'(s_data.a_x);
            aby_reg  <= DFW'(s_data.b_y) - DFW'(s_data.a_y);
            ncdx_reg <= DFW'(s_data.c_x) - DFW'(s_data.d_x);
            ncdy_reg <= DFW'(s_data.c_y) - DFW'(s_data.d_y);
            acx_reg  <= DFW'(s_data.c_x) - DFW'(s_data.a_x);
            acy_reg  <= DFW'(s_data.c_y) - DFW'(s_data.a_y);
            ax1_reg  <= s_data.a_x;
            ay1_reg  <= s_data.a_y;
        end
    end

    // stage 2: six products, one multiplier each
    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            p0_reg   <= PW'(abx_reg) * PW'(ncdy_reg);
            p1_reg   <= PW'(ncdx_reg) * PW'(aby_reg);
            p2_reg   <= PW'(acx_reg) * PW'(ncdy_reg);
            p3_reg   <= PW'(ncdx_reg) * PW'(acy_reg);
            p4_reg   <= PW'(abx_reg) * PW'(acy_reg);
            p5_reg   <= PW'(acx_reg) * PW'(aby_reg);
            abx2_reg <= abx_reg;
            aby2_reg <= aby_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
        end
    end

    // stage 3: determinants
    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            delta_reg  <= DTW'(p0_reg) - DTW'(p1_reg);
            delta1_reg <= DTW'(p2_reg) - DTW'(p3_reg);
            delta2_reg <= DTW'(p4_reg) - DTW'(p5_reg);
            abx3_reg   <= abx2_reg;
            aby3_reg   <= aby2_reg;
            ax3_reg    <= ax2_reg;
            ay3_reg    <= ay2_reg;
        end
    end

    // stage 4: both fractions in [0,1] tested exactly on the determinants
    logic                  den_pos;
    logic                  in1, in2;
    logic signed [DTW-1:0] mag_d, mag_1;
    logic signed [DFW-1:0] mag_x, mag_y;

    always_comb begin
        den_pos = delta_reg > 0;
        if (den_pos) begin
            in1 = (delta1_reg >= 0) && (delta1_reg <= delta_reg);
            in2 = (delta2_reg >= 0) && (delta2_reg <= delta_reg);
        end else begin
            in1 = (delta1_reg <= 0) && (delta1_reg >= delta_reg);
            in2 = (delta2_reg <= 0) && (delta2_reg >= delta_reg);
        end
        mag_d = (delta_reg < 0) ? -delta_reg : delta_reg;
        mag_1 = (delta1_reg < 0) ? -delta1_reg : delta1_reg;
        mag_x = (abx3_reg < 0) ? -abx3_reg : abx3_reg;
        mag_y = (aby3_reg < 0) ? -aby3_reg : aby3_reg;

        c4_next.crosses = (delta_reg != 0) && in1 && in2;
        c4_next.n       = mag_1[DW-1:0];
        c4_next.den     = mag_d[DW-1:0];
        c4_next.lx.a0   = ax3_reg;
        c4_next.lx.neg  = abx3_reg < 0;
        c4_next.lx.m    = mag_x[CW-1:0];
        c4_next.lx.q    = '0;
        c4_next.lx.r    = '0;
        c4_next.ly.a0   = ay3_reg;
        c4_next.ly.neg  = aby3_reg < 0;
        c4_next.ly.m    = mag_y[CW-1:0];
        c4_next.ly.q    = '0;
        c4_next.ly.r    = '0;
        // parallel case: keep the divisor nonzero so the chain stays defined
        if (delta_reg == 0) begin
            c4_next.den = {{(DW-1){1'b0}}, 1'b1};
            c4_next.n   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            c4_reg <= c4_next;
        end
    end

    assign chain_valid[0] = v4_reg;
    assign chain_data[0]  = c4_reg;
    assign chain_ready[CW] = rdyo;

    // one cell per bit of |d|, most significant first
    for (genvar k = 0; k < CW; k++) begin : g_cell
        sic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    // final: a0 +/- q, remainder pulls the result toward zero
    sic_pkg::cell_t        tail;
    logic signed [CW+1:0]  vx, vy;

    always_comb begin
        tail = chain_data[CW];
        if (tail.lx.neg) begin
            vx = (CW+2)'(tail.lx.a0) - $signed({2'b00, tail.lx.q});
            if ((tail.lx.r != '0) && (vx > 0)) begin
                vx = vx - (CW+2)'(1);
            end
        end else begin
            vx = (CW+2)'(tail.lx.a0) + $signed({2'b00, tail.lx.q});
            if ((tail.lx.r != '0) && (vx < 0)) begin
                vx = vx + (CW+2)'(1);
            end
        end
        if (tail.ly.neg) begin
            vy = (CW+2)'(tail.ly.a0) - $signed({2'b00, tail.ly.q});
            if ((tail.ly.r != '0) && (vy > 0)) begin
                vy = vy - (CW+2)'(1);
            end
        end else begin
            vy = (CW+2)'(tail.ly.a0) + $signed({2'b00, tail.ly.q});
            if ((tail.ly.r != '0) && (vy < 0)) begin
                vy = vy + (CW+2)'(1);
            end
        end
        out_next.crosses = tail.crosses;
        out_next.cross_x = tail.crosses ? vx[CW-1:0] : '0;
        out_next.cross_y = tail.crosses ? vy[CW-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (rdyo && chain_valid[CW]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = vo_reg;
    assign m_data  = out_reg;

endmodule

/* rtl/sic_checker.sv */
// port-level checks for the segment crossing block, bound to the top level
// depends on sic_pkg and segment_intersection_cramer
module sic_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input sic_pkg::out_t m_data
);

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // no crossing means a zero point
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.crosses |-> m_data.cross_x == '0 && m_data.cross_y == '0)
        else $error("nonzero point without crossing");

    // reset empties the pipeline
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an empty output side never blocks input
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && m_ready && !m_valid |-> s_ready)
        else $error("input stalled with idle output");

endmodule

bind segment_intersection_cramer sic_checker u_sic_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* sim/segment_intersection_cramer_chk.sv */
`timescale 1ns / 1ps
// checker for the segment crossing block: watches both channels, predicts each result
// depends on sic_pkg for the beat types
module segment_intersection_cramer_chk (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  sic_pkg::in_t   s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  sic_pkg::out_t  m_data,
    output int             errors,
    output int             pending
);

    sic_pkg::out_t crossing_q[$];

    // trunc(a0 + d*n/den) toward zero, exactly
    function automatic longint trunc_sum(longint a0, longint d, longint n, longint den);
        longint num, fl;
        num = a0 * den + d * n;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        fl = num / den;
        return fl;
    endfunction

    function automatic sic_pkg::out_t crossing_of(sic_pkg::in_t b);
        sic_pkg::out_t o;
        longint abx, aby, ncdx, ncdy, acx, acy, dl, d1, d2;
        o = '0;
        abx = longint'(b.b_x) - longint'(b.a_x);
        aby = longint'(b.b_y) - longint'(b.a_y);
        ncdx = longint'(b.c_x) - longint'(b.d_x);
        ncdy = longint'(b.c_y) - longint'(b.d_y);
        acx = longint'(b.c_x) - longint'(b.a_x);
        acy = longint'(b.c_y) - longint'(b.a_y);
        dl = abx * ncdy - ncdx * aby;
        if (dl == 0) return o;
        d1 = acx * ncdy - ncdx * acy;
        d2 = abx * acy - acx * aby;
        if (dl > 0 && (d1 < 0 || d1 > dl || d2 < 0 || d2 > dl)) return o;
        if (dl < 0 && (d1 > 0 || d1 < dl || d2 > 0 || d2 < dl)) return o;
        o.crosses = 1'b1;
        // exact rational point, truncated toward zero
        o.cross_x = sic_pkg::CW'(trunc_sum(b.a_x, abx, d1, dl));
        o.cross_y = sic_pkg::CW'(trunc_sum(b.a_y, aby, d1, dl));
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        sic_pkg::out_t want;
        if (!aresetn) begin
            errors = 0;
            pending <= 0;
        end else begin
            if (s_valid && s_ready) crossing_q.push_back(crossing_of(s_data));
            if (m_valid && m_ready) begin
                if (crossing_q.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = crossing_q.pop_front();
                    if (m_data.crosses !== want.crosses)
                        report_mismatch("crosses", m_data.crosses, want.crosses);
                    if (m_data.cross_x !== want.cross_x)
                        report_mismatch("cross_x", m_data.cross_x, want.cross_x);
                    if (m_data.cross_y !== want.cross_y)
                        report_mismatch("cross_y", m_data.cross_y, want.cross_y);
                end
            end
            pending <= crossing_q.size();
        end
    end
endmodule

/* sim/segment_intersection_cramer_tb.sv */
`timescale 1ns / 1ps
// testbench top for the segment crossing block: clock, reset, stimulus, verdict
// depends on sic_pkg, segment_intersection_cramer and segment_intersection_cramer_chk
module segment_intersection_cramer_tb;

    localparam int LATENCY = sic_pkg::CW + 5;
    localparam longint CYCLE_LIMIT = 400000;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    sic_pkg::in_t   s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    sic_pkg::out_t  m_data;
    int             errors;
    int             pending;
    longint         cycles = 0;

    // idle percentages per phase; hold_req asks the receiver for one long stall
    int    send_idle = 33;
    int    recv_idle = 87;
    logic  hold_req = 1'b0;
    logic  hold_done = 1'b0;
    int    hold_off = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    segment_intersection_cramer u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    segment_intersection_cramer_chk u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .errors(errors), .pending(pending)
    );

    // timeout watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off counted here
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_off <= 200;
            hold_done <= 1'b1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // offer one beat, with a random gap first, and wait for acceptance
    task automatic send_beat(sic_pkg::in_t b);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic signed [sic_pkg::CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return sic_pkg::CW'($urandom);
            1: return sic_pkg::CW'(-32768);
            2: return sic_pkg::CW'(32767);
            default: return sic_pkg::CW'($signed($urandom_range(40)) - 20);
        endcase
    endfunction

    // likely crossings most of the time: both segments straddle a common point in x and y
    function automatic sic_pkg::in_t rand_segments();
        sic_pkg::in_t b;
        int px, py, s;
        b.a_x = rand_coord(); b.a_y = rand_coord();
        b.b_x = rand_coord(); b.b_y = rand_coord();
        b.c_x = rand_coord(); b.c_y = rand_coord();
        b.d_x = rand_coord(); b.d_y = rand_coord();
        if ($urandom_range(99) < 60) begin
            s = ($urandom_range(1)) ? 1000 : 20;
            px = $signed($urandom_range(2 * s)) - s;
            py = $signed($urandom_range(2 * s)) - s;
            b.a_x = sic_pkg::CW'(px - $signed($urandom_range(s)));
            b.b_x = sic_pkg::CW'(px + $signed($urandom_range(s)));
            b.a_y = sic_pkg::CW'(py - $signed($urandom_range(2 * s)) + s);
            b.b_y = sic_pkg::CW'(2 * py - b.a_y);
            b.c_x = sic_pkg::CW'(px - $signed($urandom_range(2 * s)) + s);
            b.d_x = sic_pkg::CW'(2 * px - b.c_x);
            b.c_y = sic_pkg::CW'(py - $signed($urandom_range(s)));
            b.d_y = sic_pkg::CW'(py + $signed($urandom_range(s)));
        end
        return b;
    endfunction

    function automatic sic_pkg::in_t seg(int ax, int ay, int bx, int by, int cx, int cy,
                                         int dx, int dy);
        sic_pkg::in_t b;
        b.a_x = sic_pkg::CW'(ax); b.a_y = sic_pkg::CW'(ay);
        b.b_x = sic_pkg::CW'(bx); b.b_y = sic_pkg::CW'(by);
        b.c_x = sic_pkg::CW'(cx); b.c_y = sic_pkg::CW'(cy);
        b.d_x = sic_pkg::CW'(dx); b.d_y = sic_pkg::CW'(dy);
        return b;
    endfunction

    // stop offering and wait until every expected result has come
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int n;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: simple cross, end touching, parallel, collinear, point segment,
        // outside either segment, extreme coordinates, negative truncation
        send_beat(seg(0, 0, 10, 10, 0, 10, 10, 0));
        send_beat(seg(0, 0, 10, 0, 10, 0, 10, 10));
        send_beat(seg(0, 0, 10, 0, 0, 5, 10, 5));
        send_beat(seg(0, 0, 10, 0, 2, 0, 20, 0));
        send_beat(seg(3, 3, 3, 3, 0, 0, 9, 9));
        send_beat(seg(0, 0, 10, 0, 20, -5, 20, 5));
        send_beat(seg(0, 0, 10, 10, 0, 10, 4, 6));
        send_beat(seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_beat(seg(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        send_beat(seg(-32768, 0, 32767, 0, 0, -32768, 1, 32767));
        send_beat(seg(0, 0, -3, -7, -3, 0, 0, -7));
        send_beat(seg(0, 0, 3, 7, 3, 0, 0, 7));
        send_beat(seg(-1, -1, -1, -1, -1, -1, -1, -1));
        send_beat(seg(32767, 32767, -32768, -32768, 0, 0, 1, 1));
        send_beat(seg(-5, 1, 5, 2, 0, -32768, 0, 32767));
        send_beat(seg(0, 0, 1, 0, 0, 0, 0, 1));
        send_beat(seg(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));

        // receiver stalls long while the sender keeps offering beats
        hold_req <= 1'b1;
        for (n = 0; n < 60; n++) send_beat(rand_segments());
        drain();
        repeat (50) @(posedge aclk);  // sender pause with everything drained

        for (n = 0; n < 800; n++) begin
            if (n == 270) begin
                send_idle = 87;
                recv_idle = 33;
            end
            if (n == 540) begin
                send_idle = 0;
                recv_idle = 0;
            end
            send_beat(rand_segments());
        end

        drain();
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/sic_pkg.sv
rtl/sic_cell.sv
rtl/segment_intersection_cramer.sv
rtl/sic_checker.sv
sim/segment_intersection_cramer_chk.sv
sim/segment_intersection_cramer_tb.sv
